[hdl/hex_frame_octet_decoder_assert.svh]
// Assertion macros used by the hex frame decoder RTL
`ifndef HEX_FRAME_OCTET_DECODER_ASSERT_SVH
`define HEX_FRAME_OCTET_DECODER_ASSERT_SVH
`ifndef SYNTH
// Check that cons holds in the same cycle as ante
`define HFOD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("hfod assertion failed");
// Check that cons holds in the cycle after ante
`define HFOD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("hfod assertion failed");
`else
`define HFOD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define HFOD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/hfod_pkg.sv]
// Shared types, constants and digit functions of the hex frame decoder
`timescale 1ns / 1ps
package hfod_pkg;

  localparam logic [7:0] CharCr         = 8'h0D;
  localparam logic [7:0] CharNine       = 8'h39;
  localparam logic [7:0] CharZero       = 8'h30;
  localparam logic [7:0] HexAlphaOffset = 8'd55;
  localparam logic [7:0] MaxOctetsReset = 8'd16;

  localparam logic KindData = 1'b0;
  localparam logic KindEnd  = 1'b1;

  typedef enum logic [4:0] {
    PH_LEN_HI  = 5'b00001,
    PH_LEN_LO  = 5'b00010,
    PH_SEP     = 5'b00100,
    PH_DATA_HI = 5'b01000,
    PH_DATA_LO = 5'b10000
  } phase_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] octet;
    logic [7:0] declared_len;
    logic [7:0] received;
    logic       short_frame;
    logic       overflow;
  } result_t;

  // Characters above '9' map by subtracting 55, everything else by subtracting '0'
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    if (c > CharNine) begin
      v = c - HexAlphaOffset;
    end else begin
      v = c - CharZero;
    end
    return v;
  endfunction

  function automatic logic [7:0] pair_value(input logic [3:0] hi, input logic [7:0] lo_c);
    return {hi, 4'b0000} + digit_value(lo_c);
  endfunction

endpackage

[hdl/hfod_if.sv]
// Channel interfaces: character input, result output and capacity write
`timescale 1ns / 1ps
interface hfod_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

interface hfod_res_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] octet;
  logic [7:0] declared_len;
  logic [7:0] received;
  logic       short_frame;
  logic       overflow;
  modport source (output valid, output kind, output octet, output declared_len,
                  output received, output short_frame, output overflow, input ready);
  modport sink (input valid, input kind, input octet, input declared_len,
                input received, input short_frame, input overflow, output ready);
endinterface

interface hfod_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] max_octets;
  modport source (output valid, output max_octets, input ready);
  modport sink (input valid, input max_octets, output ready);
endinterface

[hdl/hfod_in_stage.sv]
// Input register: holds one received character until the decoder takes it
`timescale 1ns / 1ps
module hfod_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  input  logic       out_free_i,
  output logic       step_o,
  output logic [7:0] char_o
);

  logic       valid_q;
  logic       valid_d;
  logic [7:0] char_q;

  assign step_o     = valid_q & out_free_i;
  assign in_ready_o = ~valid_q | step_o;
  assign valid_d    = (in_valid_i & in_ready_o) | (valid_q & ~step_o);
  assign char_o     = char_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= in_char_i;
    end
  end

endmodule

[hdl/hfod_decode.sv]
// Frame state machine and per-character decode
`timescale 1ns / 1ps
`include "hex_frame_octet_decoder_assert.svh"
module hfod_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       char_i,
  input  logic [7:0]       max_octets_i,
  output logic             res_valid_o,
  output hfod_pkg::result_t res_o
);

  hfod_pkg::phase_e phase_q, phase_d;
  logic [7:0] frame_len_q, frame_len_d;
  logic [7:0] octet_count_q, octet_count_d;
  logic [7:0] pair_count_q, pair_count_d;
  logic [3:0] high_nibble_q, high_nibble_d;
  logic       overflow_q, overflow_d;
  logic [7:0] pair_v;
  logic [7:0] digit_v;

  assign pair_v  = hfod_pkg::pair_value(high_nibble_q, char_i);
  assign digit_v = hfod_pkg::digit_value(char_i);

  always_comb begin
    phase_d       = phase_q;
    frame_len_d   = frame_len_q;
    octet_count_d = octet_count_q;
    pair_count_d  = pair_count_q;
    high_nibble_d = high_nibble_q;
    overflow_d    = overflow_q;
    res_valid_o   = 1'b0;
    res_o         = '0;
    if (step_i) begin
      if (char_i == hfod_pkg::CharCr) begin
        // Frame end: report and rearm, dropping any half pair
        res_valid_o              = 1'b1;
        res_o.kind               = hfod_pkg::KindEnd;
        res_o.declared_len       = frame_len_q;
        res_o.received           = octet_count_q;
        res_o.short_frame        = pair_count_q < frame_len_q;
        res_o.overflow           = overflow_q;
        phase_d                  = hfod_pkg::PH_LEN_HI;
        frame_len_d              = '0;
        octet_count_d            = '0;
        pair_count_d             = '0;
        high_nibble_d            = '0;
        overflow_d               = 1'b0;
      end else begin
        unique case (phase_q)
          hfod_pkg::PH_LEN_LO: begin
            frame_len_d = pair_v;
            phase_d     = hfod_pkg::PH_SEP;
          end
          hfod_pkg::PH_SEP: begin
            phase_d = hfod_pkg::PH_DATA_HI;
          end
          hfod_pkg::PH_DATA_HI: begin
            high_nibble_d = digit_v[3:0];
            phase_d       = hfod_pkg::PH_DATA_LO;
          end
          hfod_pkg::PH_DATA_LO: begin
            phase_d = hfod_pkg::PH_DATA_HI;
            if (pair_count_q < frame_len_q) begin
              pair_count_d = pair_count_q + 8'd1;
              if (octet_count_q >= max_octets_i) begin
                overflow_d = 1'b1;
              end else begin
                octet_count_d      = octet_count_q + 8'd1;
                res_valid_o        = 1'b1;
                res_o.kind         = hfod_pkg::KindData;
                res_o.octet        = pair_v;
                res_o.declared_len = frame_len_q;
                res_o.received     = octet_count_q + 8'd1;
                res_o.overflow     = overflow_q;
              end
            end
          end
          default: begin
            // Length high digit
            high_nibble_d = digit_v[3:0];
            phase_d       = hfod_pkg::PH_LEN_LO;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= hfod_pkg::PH_LEN_HI;
      frame_len_q   <= '0;
      octet_count_q <= '0;
      pair_count_q  <= '0;
      high_nibble_q <= '0;
      overflow_q    <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      frame_len_q   <= frame_len_d;
      octet_count_q <= octet_count_d;
      pair_count_q  <= pair_count_d;
      high_nibble_q <= high_nibble_d;
      overflow_q    <= overflow_d;
    end
  end

  `HFOD_ASSERT_SAME(a_kept_le_pairs, clk_i, rst_ni, 1'b1, octet_count_q <= pair_count_q)
  `HFOD_ASSERT_SAME(a_pairs_le_len, clk_i, rst_ni, 1'b1, pair_count_q <= frame_len_q)
  `HFOD_ASSERT_NEXT(a_cr_rearms, clk_i, rst_ni, step_i && (char_i == hfod_pkg::CharCr), (phase_q == hfod_pkg::PH_LEN_HI) && (pair_count_q == 8'd0))
  `HFOD_ASSERT_SAME(a_data_counted, clk_i, rst_ni, res_valid_o && (res_o.kind == hfod_pkg::KindData), res_o.received != 8'd0)

endmodule

[hdl/hfod_out_reg.sv]
// Result register: holds one result until the receiver takes it
`timescale 1ns / 1ps
module hfod_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  hfod_pkg::result_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hfod_pkg::result_t res_o
);

  logic              valid_q;
  logic              valid_d;
  hfod_pkg::result_t res_q;

  assign free_o      = ~valid_q | out_ready_i;
  assign valid_d     = load_i | (valid_q & ~out_ready_i);
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

[hdl/hex_frame_octet_decoder.sv]
// Top level of the hex frame octet decoder
// Usage:
//   in_ch  : one received character per transfer (char_in).
//   out_ch : one result per transfer; kind 0 carries a decoded data octet,
//            kind 1 marks frame end with declared length, received count,
//            short-frame and overflow flags.
//   cfg_ch : writes max_octets, the capacity for data octets per frame.
//            Write only while the decoder is idle; the port is always ready.
// Timing: a character sits in the input register and is decoded there; the
//   result register loads its result, if any, at the next clock edge, so
//   out_ch valid comes from the result register, behind the input register.
//   Throughput is one character per cycle while the result register is free,
//   set by the state update of the frame decoder.
// Stall: while a result waits on out_ch, the held character in the input
//   register waits too and in_ch drops ready; a character that yields no
//   result still needs the result register free to advance.
// Reset: clears both registers' valid flags, rearms the decoder for a new
//   frame and sets max_octets to 16.
`timescale 1ns / 1ps
module hex_frame_octet_decoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  hfod_char_if.sink    in_ch,
  hfod_res_if.source   out_ch,
  hfod_cfg_if.sink     cfg_ch
);

  logic              out_free;
  logic              step;
  logic [7:0]        step_char;
  logic              res_valid;
  hfod_pkg::result_t res_next;
  hfod_pkg::result_t res_held;
  logic [7:0]        max_octets_q;

  // Capacity register: take every write transfer
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_octets_q <= hfod_pkg::MaxOctetsReset;
    end else if (cfg_ch.valid) begin
      max_octets_q <= cfg_ch.max_octets;
    end
  end

  // Hold the character until the result register can take its outcome
  hfod_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .in_char_i  (in_ch.char_in),
    .out_free_i (out_free),
    .step_o     (step),
    .char_o     (step_char)
  );

  // Advance the frame state by one character
  hfod_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .char_i       (step_char),
    .max_octets_i (max_octets_q),
    .res_valid_o  (res_valid),
    .res_o        (res_next)
  );

  // Register the result toward the receiver
  hfod_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res_next),
    .free_o      (out_free),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .res_o       (res_held)
  );

  assign out_ch.kind         = res_held.kind;
  assign out_ch.octet        = res_held.octet;
  assign out_ch.declared_len = res_held.declared_len;
  assign out_ch.received     = res_held.received;
  assign out_ch.short_frame  = res_held.short_frame;
  assign out_ch.overflow     = res_held.overflow;

endmodule

[bench/hex_frame_octet_decoder_tb.sv]
// Self-checking testbench of the hex frame octet decoder
`timescale 1ns / 1ps
module hex_frame_octet_decoder_tb;

  // Track frame state and queue the results each received character must cause
  class frame_result_board;
    hfod_pkg::result_t expected_q[$];
    int                errors;
    int                data_seen;
    int                ends_seen;
    int                short_seen;
    int                overflow_ends;
    logic [7:0]        capacity;
    hfod_pkg::phase_e  phase;
    logic [7:0]        frame_len;
    logic [7:0]        kept;
    logic [7:0]        pairs_in_len;
    logic [3:0]        hi_nib;
    logic              dropped;

    function new();
      errors        = 0;
      data_seen     = 0;
      ends_seen     = 0;
      short_seen    = 0;
      overflow_ends = 0;
      capacity      = hfod_pkg::MaxOctetsReset;
      clear_frame();
    endfunction

    function void clear_frame();
      phase        = hfod_pkg::PH_LEN_HI;
      frame_len    = 8'd0;
      kept         = 8'd0;
      pairs_in_len = 8'd0;
      hi_nib       = 4'd0;
      dropped      = 1'b0;
    endfunction

    function void set_capacity(logic [7:0] value);
      capacity = value;
    endfunction

    // Characters above '9' lose 55, everything else loses '0', no range check
    function logic [7:0] weight(logic [7:0] c);
      if (c > hfod_pkg::CharNine) begin
        return c - hfod_pkg::HexAlphaOffset;
      end
      return c - hfod_pkg::CharZero;
    endfunction

    function void note_char(logic [7:0] c);
      hfod_pkg::result_t r;
      logic [7:0]        w;
      w = weight(c);
      r = '0;
      if (c == hfod_pkg::CharCr) begin
        r.kind         = hfod_pkg::KindEnd;
        r.declared_len = frame_len;
        r.received     = kept;
        r.short_frame  = (pairs_in_len < frame_len);
        r.overflow     = dropped;
        expected_q.push_back(r);
        clear_frame();
        return;
      end
      case (phase)
        hfod_pkg::PH_LEN_LO: begin
          frame_len = {hi_nib, 4'b0000} + w;
          phase     = hfod_pkg::PH_SEP;
        end
        hfod_pkg::PH_SEP: begin
          phase = hfod_pkg::PH_DATA_HI;
        end
        hfod_pkg::PH_DATA_HI: begin
          hi_nib = w[3:0];
          phase  = hfod_pkg::PH_DATA_LO;
        end
        hfod_pkg::PH_DATA_LO: begin
          phase = hfod_pkg::PH_DATA_HI;
          if (pairs_in_len < frame_len) begin
            pairs_in_len = pairs_in_len + 8'd1;
            if (kept >= capacity) begin
              dropped = 1'b1;
            end else begin
              kept           = kept + 8'd1;
              r.kind         = hfod_pkg::KindData;
              r.octet        = {hi_nib, 4'b0000} + w;
              r.declared_len = frame_len;
              r.received     = kept;
              r.overflow     = dropped;
              expected_q.push_back(r);
            end
          end
        end
        default: begin
          hi_nib = w[3:0];
          phase  = hfod_pkg::PH_LEN_LO;
        end
      endcase
    endfunction

    function void check_result(hfod_pkg::result_t got);
      hfod_pkg::result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: kind %0d octet %0d", got.kind, got.octet);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.kind != exp_r.kind) begin
        $error("kind: expected %0d actual %0d", exp_r.kind, got.kind);
        errors++;
      end
      if (got.octet != exp_r.octet) begin
        $error("octet: expected %0d actual %0d", exp_r.octet, got.octet);
        errors++;
      end
      if (got.declared_len != exp_r.declared_len) begin
        $error("declared_len: expected %0d actual %0d", exp_r.declared_len, got.declared_len);
        errors++;
      end
      if (got.received != exp_r.received) begin
        $error("received: expected %0d actual %0d", exp_r.received, got.received);
        errors++;
      end
      if (got.short_frame != exp_r.short_frame) begin
        $error("short_frame: expected %0d actual %0d", exp_r.short_frame, got.short_frame);
        errors++;
      end
      if (got.overflow != exp_r.overflow) begin
        $error("overflow: expected %0d actual %0d", exp_r.overflow, got.overflow);
        errors++;
      end
      if (exp_r.kind == hfod_pkg::KindEnd) begin
        ends_seen++;
        if (exp_r.short_frame) short_seen++;
        if (exp_r.overflow) overflow_ends++;
      end else begin
        data_seen++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  hfod_char_if in_ch ();
  hfod_res_if  out_ch ();
  hfod_cfg_if  cfg_ch ();

  hex_frame_octet_decoder dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  frame_result_board board;

  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned hold_left;
  int unsigned chars_sent;
  int unsigned capacity_writes;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off counted here cycle by cycle
  initial begin
    hfod_pkg::result_t got;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (receiver_stall_pct != 0 && $urandom_range(99) < receiver_stall_pct) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.kind         = out_ch.kind;
        got.octet        = out_ch.octet;
        got.declared_len = out_ch.declared_len;
        got.received     = out_ch.received;
        got.short_frame  = out_ch.short_frame;
        got.overflow     = out_ch.overflow;
        board.check_result(got);
      end
    end
  end

  // Offer one character, idling first at the current sender rate; note it on transfer
  task automatic send_char(input logic [7:0] c);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.char_in <= c;
    do @(posedge clk); while (!in_ch.ready);
    board.note_char(c);
    chars_sent++;
  endtask

  // Drain the decoder, wait out characters still in flight, then write the capacity
  task automatic write_capacity(input logic [7:0] value);
    in_ch.valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.max_octets <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    board.set_capacity(value);
    capacity_writes++;
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    if (n < 4'd10) begin
      return hfod_pkg::CharZero + n;
    end
    return hfod_pkg::HexAlphaOffset + n;
  endfunction

  // Mostly uppercase hex; now and then lowercase or an arbitrary non-CR byte
  function automatic logic [7:0] frame_digit(input logic [3:0] n);
    logic [7:0]  b;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 90) begin
      return hex_digit(n);
    end else if (pick < 95) begin
      return 8'h61 + 8'($urandom_range(5));
    end
    b = 8'($urandom_range(255));
    if (b == hfod_pkg::CharCr) b = 8'h2D;
    return b;
  endfunction

  // Well-formed frames with random content, some cut short by an early CR, some noise
  task automatic send_random_frame();
    logic [7:0]  chars[$];
    logic [7:0]  len8;
    logic [7:0]  rnd;
    logic [7:0]  b;
    int unsigned pick;
    int unsigned len;
    int unsigned npairs;
    int unsigned cut;
    pick = $urandom_range(99);
    if (pick >= 88) begin
      repeat ($urandom_range(1, 12)) chars.push_back(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(19) == 0) begin
        len = $urandom_range(255);
      end else begin
        len = $urandom_range(12);
      end
      if (len > 16) begin
        npairs = $urandom_range(20);
      end else begin
        npairs = $urandom_range(len + 3);
      end
      len8 = 8'(len);
      chars.push_back(frame_digit(len8[7:4]));
      chars.push_back(frame_digit(len8[3:0]));
      b = 8'($urandom_range(255));
      if (b == hfod_pkg::CharCr) b = 8'h2D;
      chars.push_back(b);
      repeat (npairs) begin
        rnd = 8'($urandom_range(255));
        chars.push_back(frame_digit(rnd[7:4]));
        chars.push_back(frame_digit(rnd[3:0]));
      end
      // Cut the frame anywhere: inside the length, at the separator or mid pair
      if (pick >= 72) begin
        cut = $urandom_range(chars.size() - 1);
        while (chars.size() > cut) void'(chars.pop_back());
      end
    end
    chars.push_back(hfod_pkg::CharCr);
    foreach (chars[i]) send_char(chars[i]);
  endtask

  task automatic send_string(input logic [7:0] chars[$]);
    foreach (chars[i]) send_char(chars[i]);
  endtask

  initial begin
    logic [7:0]  caps[8];
    int unsigned seg;
    board              = new();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_left          = 0;
    chars_sent         = 0;
    capacity_writes    = 0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.char_in      = 8'h00;
    cfg_ch.valid       = 1'b0;
    cfg_ch.max_octets  = 8'h00;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme bytes as data digits and a non-hex separator, at reset capacity
    send_string('{"0", "2", 8'hFF, 8'h00, 8'hFF, "F", "F", hfod_pkg::CharCr});
    // CR inside the length field
    send_string('{"A", hfod_pkg::CharCr});
    // CR between the two digits of a pair: half pair dropped, frame short
    send_string('{"1", "0", " ", "7", hfod_pkg::CharCr});
    // Capacity of one: second pair dropped, third pair beyond the length
    write_capacity(8'd1);
    send_string('{"0", "2", "-", "A", "A", "B", "B", "C", "C", hfod_pkg::CharCr});

    caps[0] = 8'd16;
    caps[1] = 8'd0;
    caps[2] = 8'd255;
    caps[3] = 8'd3;
    caps[4] = 8'd1;
    caps[5] = 8'($urandom_range(255));
    caps[6] = 8'd255;
    caps[7] = 8'($urandom_range(8));

    // Random: walk through the idle mixes twice, each stretch at its own capacity
    for (seg = 0; seg < 8; seg++) begin
      write_capacity(caps[seg]);
      case (seg % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 63;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 63;
        end
        default: begin
          sender_idle_pct    = 34;
          receiver_stall_pct = 34;
        end
      endcase
      // Hold the output long enough for the decoder to back up into its input
      if (seg == 4) hold_left = 300;
      while (chars_sent < 25 + (seg + 1) * 212) send_random_frame();
    end

    in_ch.valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("Sent %0d characters over %0d capacity writes; four idle mixes, one long hold.",
             chars_sent, capacity_writes);
    $display("Checked %0d data octets and %0d frame ends (%0d short, %0d with overflow).",
             board.data_seen, board.ends_seen, board.short_seen, board.overflow_ends);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
